// ----- rtl/core/tbps_pkg.sv -----
// Shared types and constants of the token bucket packet shaper.
`default_nettype none
package tbps_pkg;

  localparam int SizeW = 16;
  localparam int TokW  = 32;
  localparam int CapW  = 24;
  localparam int StatW = 16;

  localparam logic [TokW-1:0]  BucketSizeReset = 32'd1024;
  localparam logic [TokW-1:0]  TokenRateReset  = 32'd128;
  localparam logic [CapW-1:0]  QueueCapReset   = 24'd4096;
  localparam logic [31:0]      MaxPacketSize   = 32'd65535;
  localparam logic [StatW-1:0] StatMax         = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CfgBucketSize = 2'd0;
  localparam logic [1:0] CfgTokenRate  = 2'd1;
  localparam logic [1:0] CfgQueueCap   = 2'd2;

  // Input opcodes.
  localparam logic OpTick    = 1'b0;
  localparam logic OpArrival = 1'b1;

  // Requests from the shaper control to the size queue.
  typedef struct packed {
    logic             look;    // an item transfer: read the head entry
    logic             push;    // enqueue size
    logic             pop;     // dequeue the head entry
    logic             cap_wr;  // queue capacity register write
    logic [SizeW-1:0] size;
    logic [CapW-1:0]  cap;
  } tbps_qcmd_t;

  // Status of the size queue.
  typedef struct packed {
    logic             fits;       // an arrival of cmd size would be enqueued
    logic             nonempty;
    logic [SizeW-1:0] head_size;  // valid the cycle after a look
    logic [CapW-1:0]  free_d;     // free bytes after this cycle's updates
  } tbps_qstat_t;

endpackage
`default_nettype wire

// ----- rtl/core/tbps_size_mem.sv -----
// Synchronous single-write, single-read memory of queued packet sizes.
`default_nettype none
module tbps_size_mem #(
  parameter int QUEUE_DEPTH = 64,
  localparam int AddrW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [tbps_pkg::SizeW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [tbps_pkg::SizeW-1:0] rdata_o
);
  import tbps_pkg::*;

  logic [SizeW-1:0] mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tbps_queue.sv -----
// Byte-limited FIFO of packet sizes: pointers, counts, free space and head forwarding.
`default_nettype none
module tbps_queue #(
  parameter int QUEUE_DEPTH = 64,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tbps_pkg::tbps_qcmd_t  cmd_i,
  output tbps_pkg::tbps_qstat_t      stat_o,
  output logic [CntW-1:0]            count_d_o
);
  import tbps_pkg::*;

  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int UsedW = SizeW + CntW;
  localparam int CmpW  = (UsedW > CapW) ? UsedW : CapW;

  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [CapW-1:0]  cap_q, cap_d, free_q, free_d;
  logic             fwd_q;
  logic [SizeW-1:0] fsize_q, rdata, head_size;
  logic [CmpW-1:0]  cap_ext, used_ext, diff;

  function automatic logic [PtrW-1:0] wrap_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  tbps_size_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.size),
    .re_i    (cmd_i.look),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  // An arrival written into an empty queue is its own head; the memory read
  // in that same cycle returns stale data, so the size is forwarded.
  assign head_size = fwd_q ? fsize_q : rdata;

  always_comb begin
    head_d  = cmd_i.pop ? wrap_next(head_q) : head_q;
    tail_d  = cmd_i.push ? wrap_next(tail_q) : tail_q;
    count_d = count_q;
    used_d  = used_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
      used_d  = used_q + {{(UsedW-SizeW){1'b0}}, cmd_i.size};
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
      used_d  = used_q - {{(UsedW-SizeW){1'b0}}, head_size};
    end
    cap_d    = cmd_i.cap_wr ? cmd_i.cap : cap_q;
    cap_ext  = CmpW'(cap_d);
    used_ext = CmpW'(used_d);
    diff     = cap_ext - used_ext;
    free_d   = (cap_ext > used_ext) ? diff[CapW-1:0] : '0;
  end

  assign stat_o.fits = (count_q < CntW'(QUEUE_DEPTH)) &&
                       ({{(32-CapW){1'b0}}, free_q} >= 32'(cmd_i.size)) &&
                       (32'(cmd_i.size) <= MaxPacketSize);
  assign stat_o.nonempty  = (count_q != '0);
  assign stat_o.head_size = head_size;
  assign stat_o.free_d    = free_d;
  assign count_d_o        = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      used_q  <= '0;
      cap_q   <= QueueCapReset;
      free_q  <= QueueCapReset;
      fwd_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      used_q  <= used_d;
      cap_q   <= cap_d;
      free_q  <= free_d;
      if (cmd_i.look) begin
        fwd_q <= cmd_i.push && (count_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      fsize_q <= cmd_i.size;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/token_bucket_packet_shaper_unit.sv -----
// Top level of the token bucket packet shaper: bucket, tick counters and result register.
// A result is registered as the execute state after its input transfer ends; that state
// waits while an earlier result stalls the output, and items are taken only when idle. The
// send decision waits in the execute state for the head size from the synchronous size memory.
// A new item is taken while the previous result still waits at the output.
// Reset (asynchronous, active low) restores register defaults, a full bucket and an empty queue.
`default_nettype none
module token_bucket_packet_shaper_unit #(
  parameter int QUEUE_DEPTH = 64,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [15:0] packet_size_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic             dropped_o,
  output logic             sent_o,
  output logic [15:0]      sent_size_o,
  output logic [31:0]      token_count_o,
  output logic [CntW-1:0]  queued_packets_o,
  output logic [23:0]      free_bytes_o,
  output logic [15:0]      tick_arrived_o,
  output logic [15:0]      tick_departed_o,
  output logic [15:0]      tick_dropped_o
);
  import tbps_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e           state_q;
  logic [TokW-1:0]  bucket_q, rate_q, tokens_q;
  logic             blocked_q, op_q, acc_q;
  logic [StatW-1:0] arr_q, dep_q, drp_q;
  logic             out_valid_q;

  tbps_qcmd_t       qcmd;
  tbps_qstat_t      qstat;
  logic [CntW-1:0]  count_d;

  logic             accept, finish, send;
  logic [TokW:0]    tok_sum;
  logic [TokW-1:0]  tok_tick;

  function automatic logic [StatW-1:0] sat_inc(input logic [StatW-1:0] v);
    logic [StatW-1:0] r;
    r = (v == StatMax) ? StatMax : v + 1'b1;
    return r;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Once a send fails, no further send is tried until the next tick.
  assign send = (op_q == OpArrival) && !blocked_q && qstat.nonempty &&
                (tokens_q >= {{(TokW-SizeW){1'b0}}, qstat.head_size});

  assign tok_sum  = {1'b0, tokens_q} + {1'b0, rate_q};
  assign tok_tick = (tok_sum > {1'b0, bucket_q}) ? bucket_q : tok_sum[TokW-1:0];

  always_comb begin
    qcmd.look   = accept;
    qcmd.size   = packet_size_i;
    qcmd.push   = accept && (opcode_i == OpArrival) && qstat.fits;
    qcmd.pop    = finish && send;
    qcmd.cap_wr = cfg_we_i && (cfg_idx_i == CfgQueueCap);
    qcmd.cap    = cfg_data_i[CapW-1:0];
  end

  tbps_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (qcmd),
    .stat_o    (qstat),
    .count_d_o (count_d)
  );

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bucket_q    <= BucketSizeReset;
      rate_q      <= TokenRateReset;
      tokens_q    <= BucketSizeReset;
      blocked_q   <= 1'b0;
      arr_q       <= '0;
      dep_q       <= '0;
      drp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CfgBucketSize)) begin
        bucket_q <= cfg_data_i;
        tokens_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CfgTokenRate)) begin
        rate_q <= cfg_data_i;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
            if (opcode_i == OpArrival) begin
              arr_q <= sat_inc(arr_q);
              if (!qstat.fits) begin
                drp_q <= sat_inc(drp_q);
              end
            end
          end
        end
        S_EXEC: begin
          if (finish) begin
            state_q <= S_IDLE;
            if (op_q == OpTick) begin
              tokens_q  <= tok_tick;
              blocked_q <= 1'b0;
              arr_q     <= '0;
              dep_q     <= '0;
              drp_q     <= '0;
            end else if (send) begin
              tokens_q <= tokens_q - {{(TokW-SizeW){1'b0}}, qstat.head_size};
              dep_q    <= sat_inc(dep_q);
            end else begin
              blocked_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      acc_q <= qcmd.push;
    end
    if (finish) begin
      accepted_o       <= (op_q == OpArrival) && acc_q;
      dropped_o        <= (op_q == OpArrival) && !acc_q;
      sent_o           <= send;
      sent_size_o      <= send ? qstat.head_size : '0;
      token_count_o    <= (op_q == OpTick) ? tok_tick :
                          (send ? tokens_q - {{(TokW-SizeW){1'b0}}, qstat.head_size}
                                : tokens_q);
      queued_packets_o <= count_d;
      free_bytes_o     <= qstat.free_d;
      tick_arrived_o   <= (op_q == OpTick) ? arr_q : '0;
      tick_departed_o  <= (op_q == OpTick) ? dep_q : '0;
      tick_dropped_o   <= (op_q == OpTick) ? drp_q : '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tbps_checker.sv -----
// Port-level checks of the token bucket packet shaper, bound to its top level.
`default_nettype none
module tbps_checker #(
  parameter int QUEUE_DEPTH = 64,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            cfg_we_i,
  input wire logic [1:0]      cfg_idx_i,
  input wire logic [31:0]     cfg_data_i,
  input wire logic            in_valid_i,
  input wire logic            in_ready_o,
  input wire logic            opcode_i,
  input wire logic [15:0]     packet_size_i,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic            accepted_o,
  input wire logic            dropped_o,
  input wire logic            sent_o,
  input wire logic [15:0]     sent_size_o,
  input wire logic [31:0]     token_count_o,
  input wire logic [CntW-1:0] queued_packets_o,
  input wire logic [23:0]     free_bytes_o,
  input wire logic [15:0]     tick_arrived_o,
  input wire logic [15:0]     tick_departed_o,
  input wire logic [15:0]     tick_dropped_o
);

  // An arrival is either enqueued or dropped, never both.
  a_acc_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && dropped_o))
    else $error("accepted and dropped on one result");

  // Only an arrival can send, and a result without a send reports no size.
  a_send_on_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((sent_o && (accepted_o || dropped_o)) ||
                     (!sent_o && (sent_size_o == '0))))
    else $error("send outside an arrival, or size without a send");

  // The queue never reports more packets than it has entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (queued_packets_o <= CntW'(QUEUE_DEPTH)))
    else $error("queued packet count above queue depth");

  // Arrival results carry no tick counts.
  a_tick_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (accepted_o || dropped_o)) |->
      ((tick_arrived_o == '0) && (tick_departed_o == '0) && (tick_dropped_o == '0)))
    else $error("tick counts on an arrival result");

  // A stalled result stays valid and keeps its token count and free bytes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(token_count_o) &&
                                       $stable(free_bytes_o)))
    else $error("result changed while stalled");

endmodule

bind token_bucket_packet_shaper_unit tbps_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tbps_checker (.*);
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench of the token bucket packet shaper: bucket and queue predictor, random traffic, stalls.
`timescale 1ns / 1ps
module tb;
  import tbps_pkg::*;

  localparam int QDepth = 64;
  localparam logic [1:0] CfgUnused = 2'd3;

  localparam int PhaseNone = 0;
  localparam int PhaseBoth = 3;
  localparam int SndIdlePct[4] = '{0, 47, 0, 10};
  localparam int RcvStallPct[4] = '{0, 0, 47, 10};

  typedef struct packed {
    logic        accepted;
    logic        dropped;
    logic        sent;
    logic [15:0] sent_size;
    logic [31:0] tokens;
    logic [6:0]  queued;
    logic [23:0] free_bytes;
    logic [15:0] tick_arrived;
    logic [15:0] tick_departed;
    logic [15:0] tick_dropped;
  } shaper_result_t;

  class shaper_scoreboard;
    logic [31:0]    bucket_size;
    logic [31:0]    token_rate;
    logic [23:0]    queue_cap;
    logic [31:0]    tokens;
    logic [31:0]    queued_bytes;
    logic [23:0]    free_space;
    logic [15:0]    sizes [QDepth];
    int unsigned    head;
    int unsigned    tail;
    int unsigned    count;
    bit             send_blocked;
    logic [15:0]    n_arrived;
    logic [15:0]    n_departed;
    logic [15:0]    n_dropped;
    shaper_result_t expected_results[$];
    int unsigned    errors;

    function new();
      bucket_size  = BucketSizeReset;
      token_rate   = TokenRateReset;
      queue_cap    = QueueCapReset;
      tokens       = BucketSizeReset;
      queued_bytes = '0;
      head         = 0;
      tail         = 0;
      count        = 0;
      send_blocked = 1'b0;
      n_arrived    = '0;
      n_departed   = '0;
      n_dropped    = '0;
      errors       = 0;
      refresh_free();
    endfunction

    function void refresh_free();
      free_space = (32'(queue_cap) > queued_bytes) ? queue_cap - queued_bytes[23:0] : '0;
    endfunction

    function logic [15:0] sat16(logic [15:0] v);
      return (v == StatMax) ? v : v + 16'd1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CfgBucketSize: begin
          bucket_size = data;
          tokens      = data;
        end
        CfgTokenRate: token_rate = data;
        CfgQueueCap: begin
          queue_cap = data[23:0];
          refresh_free();
        end
        default: ;
      endcase
    endfunction

    // Works out the result of one input transfer and queues it.
    function void note_item(logic op, logic [15:0] size);
      shaper_result_t r;
      logic [32:0]    sum;
      r = '0;
      if (op == OpTick) begin
        sum = {1'b0, tokens} + {1'b0, token_rate};
        tokens = (sum > {1'b0, bucket_size}) ? bucket_size : sum[31:0];
        send_blocked    = 1'b0;
        r.tick_arrived  = n_arrived;
        r.tick_departed = n_departed;
        r.tick_dropped  = n_dropped;
        n_arrived  = '0;
        n_departed = '0;
        n_dropped  = '0;
      end else begin
        n_arrived = sat16(n_arrived);
        if (count < QDepth && {8'd0, size} <= free_space && 32'(size) <= MaxPacketSize) begin
          sizes[tail]  = size;
          tail         = (tail + 1) % QDepth;
          count++;
          queued_bytes += 32'(size);
          refresh_free();
          r.accepted = 1'b1;
        end else begin
          n_dropped = sat16(n_dropped);
          r.dropped = 1'b1;
        end
        // Once a send fails, nothing departs until the next tick.
        if (!send_blocked) begin
          if (count > 0 && tokens >= 32'(sizes[head])) begin
            r.sent_size  = sizes[head];
            head         = (head + 1) % QDepth;
            count--;
            queued_bytes -= 32'(r.sent_size);
            refresh_free();
            tokens     -= 32'(r.sent_size);
            n_departed = sat16(n_departed);
            r.sent     = 1'b1;
          end else begin
            send_blocked = 1'b1;
          end
        end
      end
      r.tokens     = tokens;
      r.queued     = 7'(count);
      r.free_bytes = free_space;
      expected_results.push_back(r);
    endfunction

    function void cmp_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(shaper_result_t got);
      shaper_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none, actual %p", $time, got);
        return;
      end
      want = expected_results.pop_front();
      cmp_field("accepted", want.accepted, got.accepted);
      cmp_field("dropped", want.dropped, got.dropped);
      cmp_field("sent", want.sent, got.sent);
      cmp_field("sent_size", want.sent_size, got.sent_size);
      cmp_field("token_count", want.tokens, got.tokens);
      cmp_field("queued_packets", want.queued, got.queued);
      cmp_field("free_bytes", want.free_bytes, got.free_bytes);
      cmp_field("tick_arrived", want.tick_arrived, got.tick_arrived);
      cmp_field("tick_departed", want.tick_departed, got.tick_departed);
      cmp_field("tick_dropped", want.tick_dropped, got.tick_dropped);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = OpTick;
  logic [15:0] packet_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic        dropped_o;
  logic        sent_o;
  logic [15:0] sent_size_o;
  logic [31:0] token_count_o;
  logic [6:0]  queued_packets_o;
  logic [23:0] free_bytes_o;
  logic [15:0] tick_arrived_o;
  logic [15:0] tick_departed_o;
  logic [15:0] tick_dropped_o;

  shaper_scoreboard sb;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int rcv_hold = 0;

  token_bucket_packet_shaper_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .packet_size_i   (packet_size_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .dropped_o       (dropped_o),
    .sent_o          (sent_o),
    .sent_size_o     (sent_size_o),
    .token_count_o   (token_count_o),
    .queued_packets_o(queued_packets_o),
    .free_bytes_o    (free_bytes_o),
    .tick_arrived_o  (tick_arrived_o),
    .tick_departed_o (tick_departed_o),
    .tick_dropped_o  (tick_dropped_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic set_phase(input int p);
    snd_idle_pct  = SndIdlePct[p];
    rcv_stall_pct = RcvStallPct[p];
  endtask

  // Valid stays high from one transfer to the next unless an idle cycle is drawn.
  task automatic send_item(input logic op, input logic [15:0] size);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    packet_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, size);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Registers change only with the block idle and every result collected.
  task automatic apply_settings(input logic [2:0] mask, input logic [31:0] bucket,
                                input logic [31:0] rate, input logic [31:0] cap,
                                input bit bogus);
    wait_drain();
    repeat (4) @(posedge clk_i);
    if (mask[0]) write_reg(CfgBucketSize, bucket);
    if (mask[1]) write_reg(CfgTokenRate, rate);
    if (mask[2]) write_reg(CfgQueueCap, cap);
    if (bogus) write_reg(CfgUnused, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    shaper_result_t got;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.accepted      = accepted_o;
        got.dropped       = dropped_o;
        got.sent          = sent_o;
        got.sent_size     = sent_size_o;
        got.tokens        = token_count_o;
        got.queued        = queued_packets_o;
        got.free_bytes    = free_bytes_o;
        got.tick_arrived  = tick_arrived_o;
        got.tick_departed = tick_departed_o;
        got.tick_dropped  = tick_dropped_o;
        sb.check_result(got);
      end
      if (rcv_hold > 0) begin
        out_ready_i <= 1'b0;
        rcv_hold--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    int          seg;
    int          n;
    int          r;
    logic [31:0] bucket;
    logic [31:0] rate;
    logic [31:0] cap;
    logic [15:0] size;
    sb = new();
    set_phase(PhaseBoth);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings, then at the extremes.
    send_item(OpTick, 16'hFFFF);
    send_item(OpArrival, 16'd0);
    send_item(OpArrival, 16'd1000);
    send_item(OpArrival, 16'd5000);  // too big and the queue is empty: sending blocks
    send_item(OpArrival, 16'd500);
    send_item(OpArrival, 16'd600);
    send_item(OpTick, 16'd0);
    send_item(OpArrival, 16'hFFFF);
    send_item(OpTick, 16'd1);
    // Zero capacity with packets still queued; a zero-size arrival still fits.
    apply_settings(3'b100, '0, '0, 32'hFF00_0000, 1'b0);
    send_item(OpArrival, 16'd0);
    send_item(OpArrival, 16'd1);
    apply_settings(3'b011, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b1);
    send_item(OpTick, 16'h5555);
    send_item(OpArrival, 16'd0);
    send_item(OpArrival, 16'd0);
    send_item(OpArrival, 16'd7);
    apply_settings(3'b111, 32'd0, 32'd0, 32'h00FF_FFFF, 1'b0);
    send_item(OpTick, 16'hAAAA);
    send_item(OpArrival, 16'hFFFF);
    send_item(OpArrival, 16'd1);
    send_item(OpArrival, 16'd2);
    send_item(OpTick, 16'd0);

    // Long ticks under a full bucket that never refills.
    set_phase(PhaseNone);
    apply_settings(3'b111, 32'hFFFF_FFFF, 32'd0, 32'h5A00_0000, 1'b0);
    send_item(OpTick, 16'd0);
    repeat (40) send_item(OpArrival, 16'd1);
    send_item(OpTick, 16'd0);
    repeat (10) send_item(OpArrival, 16'd0);
    repeat (10) send_item(OpArrival, 16'($urandom_range(65535, 1)));
    send_item(OpTick, 16'd0);

    for (seg = 0; seg < 8; seg++) begin
      set_phase(seg % 4);
      case ($urandom_range(9))
        0: bucket = 32'd0;
        1: bucket = 32'hFFFF_FFFF;
        2: bucket = $urandom;
        default: bucket = $urandom_range(8192, 256);
      endcase
      case ($urandom_range(9))
        0: rate = 32'd0;
        1: rate = 32'hFFFF_FFFF;
        2: rate = $urandom;
        default: rate = $urandom_range(2048, 16);
      endcase
      case ($urandom_range(9))
        0: cap = 32'd0;
        1: cap = 32'h00FF_FFFF;
        2: cap = $urandom;
        default: cap = $urandom_range(65536, 1024);
      endcase
      cap[31:24] = 8'($urandom);
      apply_settings((seg == 0) ? 3'b111 : 3'($urandom_range(7, 1)), bucket, rate, cap,
                     $urandom_range(3) == 0);
      // A long receiver stall while items keep coming fills the block up.
      if (seg == 4) rcv_hold = 150;
      for (n = 0; n < 40; n++) begin
        if (seg == 6 && n == 25) wait_drain();
        r = $urandom_range(99);
        if (r < 12) begin
          send_item(OpTick, 16'($urandom));
        end else begin
          r = $urandom_range(99);
          if (r < 5) size = 16'd0;
          else if (r < 10) size = 16'hFFFF;
          else if (r < 55) size = 16'($urandom_range(255, 1));
          else if (r < 80) size = 16'($urandom_range(4095, 256));
          else size = 16'($urandom);
          send_item(OpArrival, size);
        end
      end
    end

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
